/* rtl/u8df_pkg.sv */
// Package for the UTF-8 decode filter: decoder state, result type, range checks.
package u8df_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_W-1:0] CTRL_END    = 21'h000020;
  localparam logic [CP_W-1:0] DEL_CP      = 21'h00007F;
  localparam logic [CP_W-1:0] C1_END      = 21'h0000A0;
  localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;

  // sequence length codes
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef struct packed {
    logic [1:0]      bytes_remaining;
    logic [2:0]      sequence_length;
    logic [CP_W-1:0] partial_value;
  } dec_state_t;

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
  } dec_result_t;

  localparam dec_state_t DEC_IDLE = '{2'd0, SEQ_NONE, '0};

  function automatic logic [CP_W-1:0] min_value(input logic [2:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      SEQ_LEN2: v = MIN_LEN2;
      SEQ_LEN3: v = MIN_LEN3;
      SEQ_LEN4: v = MIN_LEN4;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // not a C0 control, DEL or C1 control
  function automatic logic printable(input logic [CP_W-1:0] cp);
    return !((cp < CTRL_END) || ((cp >= DEL_CP) && (cp < C1_END)));
  endfunction

  function automatic logic scalar_ok(input logic [CP_W-1:0] cp);
    return (cp <= CP_MAX) && !((cp >= SURR_LO) && (cp <= SURR_HI));
  endfunction

endpackage

/* rtl/u8df_if.sv */
// Valid/ready channel interfaces for the byte input and the code point output.
interface u8df_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       string_end;

  modport source (output valid, output byte_in, output string_end, input ready);
  modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface

interface u8df_out_if;
  logic                         valid;
  logic                         ready;
  logic [u8df_pkg::CP_W-1:0]    code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

/* rtl/u8df_step.sv */
// Combinational decode of one byte against the current sequence state.
module u8df_step (
  input  u8df_pkg::dec_state_t  st,
  input  logic [7:0]            byte_in,
  input  logic                  string_end,
  output u8df_pkg::dec_state_t  st_nxt,
  output u8df_pkg::dec_result_t res
);

  logic                      lead;
  logic [u8df_pkg::CP_W-1:0] pv;
  logic [1:0]                br;

  always_comb begin
    st_nxt = st;
    res    = '0;
    lead   = 1'b1;
    pv     = {st.partial_value[u8df_pkg::CP_W-7:0], byte_in[5:0]};
    br     = st.bytes_remaining - 2'd1;

    if (st.bytes_remaining != 2'd0) begin
      if (byte_in[7:6] == 2'b10) begin
        lead                   = 1'b0;
        st_nxt.partial_value   = pv;
        st_nxt.bytes_remaining = br;
        if (br == 2'd0) begin
          // sequence complete: range, overlong, surrogate and control checks
          st_nxt         = u8df_pkg::DEC_IDLE;
          res.code_point = pv;
          res.emit       = (pv >= u8df_pkg::min_value(st.sequence_length)) &&
                           u8df_pkg::scalar_ok(pv) && u8df_pkg::printable(pv);
        end
      end else begin
        // broken sequence; this byte restarts as a lead
        st_nxt = u8df_pkg::DEC_IDLE;
      end
    end

    if (lead) begin
      if (!byte_in[7]) begin
        res.code_point = {13'd0, byte_in};
        res.emit       = u8df_pkg::printable({13'd0, byte_in});
      end else if (byte_in[7:5] == 3'b110) begin
        st_nxt = '{2'd1, u8df_pkg::SEQ_LEN2, {16'd0, byte_in[4:0]}};
      end else if (byte_in[7:4] == 4'b1110) begin
        st_nxt = '{2'd2, u8df_pkg::SEQ_LEN3, {17'd0, byte_in[3:0]}};
      end else if (byte_in[7:3] == 5'b11110) begin
        st_nxt = '{2'd3, u8df_pkg::SEQ_LEN4, {18'd0, byte_in[2:0]}};
      end
      // other leads dropped
    end

    if (string_end && (st_nxt.bytes_remaining != 2'd0)) begin
      st_nxt = u8df_pkg::DEC_IDLE;
    end
  end

endmodule

/* rtl/utf8_decode_filter_unit.sv */
// Top level of the validating UTF-8 decoder with control-character filter.
// Takes one byte per transaction and gives at most one 21-bit code point per byte.
// Sustained rate is one byte per clock while out_chan.ready is not held low: an
// input register holds the byte, the decode (sequence state update plus range
// checks) is one short combinational step, and the code point lands in an
// output register. The input side keeps taking bytes while a result waits, as
// long as the input register can drain into the output register in the same
// cycle. Malformed sequences, overlong forms, surrogates, values above U+10FFFF
// and C0/C1 controls and DEL give no transaction. With enable clear bytes are
// swallowed and the partial sequence is held, so it resumes when enable is set
// again. Write enable only while no byte is in flight.
module utf8_decode_filter_unit (
  input  logic              clk,
  input  logic              rst_n,
  u8df_in_if.sink           in_chan,
  u8df_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  // enable register
  logic enable_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // decoder state and output register
  u8df_pkg::dec_state_t      state_r;
  u8df_pkg::dec_state_t      state_nxt;
  u8df_pkg::dec_result_t     step_res;
  logic                      out_valid_r;
  logic [u8df_pkg::CP_W-1:0] out_cp_r;

  logic advance;
  logic in_take;

  // byte moves into decode when the output register is free or being emptied
  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.code_point = out_cp_r;

  u8df_step u_step (
    .st         (state_r),
    .byte_in    (s1_byte_r),
    .string_end (s1_end_r),
    .st_nxt     (state_nxt),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      enable_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_chan.byte_in;
      s1_end_r  <= in_chan.string_end;
    end
  end

  // sequence state: untouched while disabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= u8df_pkg::DEC_IDLE;
    end else if (advance && enable_r) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= enable_r && step_res.emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cp_r <= step_res.code_point;
    end
  end

endmodule

/* rtl/u8df_checker.sv */
// Port-level assertions for the UTF-8 decode filter, bound to the top level.
module u8df_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [u8df_pkg::CP_W-1:0] out_cp
);

  // a pending code point is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cp))
    else $error("code point dropped or changed while stalled");

  // only printable scalar values leave the block
  a_out_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> u8df_pkg::scalar_ok(out_cp) && u8df_pkg::printable(out_cp))
    else $error("illegal or control code point emitted");

  // reset clears the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // an empty output register never stalls the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

endmodule

bind utf8_decode_filter_unit u8df_checker u_u8df_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_cp    (out_chan.code_point)
);
